@@ design/mps_pkg.sv @@
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants of the multi-pattern scanner
// Request codes, default sizes and the control bundle that steps the
// window cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  localparam int unsigned DEF_NUM_PATTERNS    = 8;
  localparam int unsigned DEF_MAX_PATTERN_LEN = 16;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned SLOT_FW = 3;
  localparam int unsigned POS_FW  = 4;
  localparam int unsigned LEN_FW  = 5;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CNT_W   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 3'd0,
    REQ_LENGTH  = 3'd1,
    REQ_CONTENT = 3'd2,
    REQ_EOF     = 3'd3,
    REQ_READ    = 3'd4
  } req_type_e;

  localparam logic REPLY_VERDICT = 1'b0;
  localparam logic REPLY_COUNT   = 1'b1;

  // Control shared by every cell of the content window.
  typedef struct packed {
    logic shift;
    logic clear;
  } scan_ctl_t;

endpackage

`default_nettype wire

@@ design/mps_cell.sv @@
// ----------------------------------------------------------------------------
// mps_cell: one position of the content window
// Holds one recent content byte, passes it to the next cell on every content
// transaction and compares its incoming byte with the pattern byte that each
// slot aligns to this position.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_cell #(
  parameter int unsigned NUM_PATTERNS = mps_pkg::DEF_NUM_PATTERNS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mps_pkg::scan_ctl_t               ctl_i,
  input  logic [7:0]                       byte_i,
  output logic [7:0]                       byte_o,
  input  logic [NUM_PATTERNS-1:0][7:0]     aligned_i,
  input  logic [NUM_PATTERNS-1:0]          care_i,
  output logic [NUM_PATTERNS-1:0]          hit_o
);
  import mps_pkg::*;

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctl_i.clear) begin
      byte_q <= '0;
    end else if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // The compare uses the byte this cell takes in, so a hit reflects the
  // window after the new content byte has entered.
  for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_cmp
    assign hit_o[s] = !care_i[s] || (byte_i == aligned_i[s]);
  end

endmodule

`default_nettype wire

@@ design/mps_slot.sv @@
// ----------------------------------------------------------------------------
// mps_slot: one pattern slot
// Stores the pattern bytes and length of one slot and presents the pattern
// reversed and aligned to its last byte, so that window position d meets
// pattern byte length-1-d.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_slot #(
  parameter  int unsigned MAX_PATTERN_LEN = mps_pkg::DEF_MAX_PATTERN_LEN,
  localparam int unsigned PosW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1,
  localparam int unsigned LenW = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_byte_en_i,
  input  logic [PosW-1:0]                   wr_pos_i,
  input  logic [7:0]                        wr_byte_i,
  input  logic                              wr_len_en_i,
  input  logic [LenW-1:0]                   wr_len_i,
  output logic [LenW-1:0]                   len_o,
  output logic [MAX_PATTERN_LEN-1:0][7:0]   aligned_o,
  output logic [MAX_PATTERN_LEN-1:0]        care_o
);
  import mps_pkg::*;

  logic [7:0]                   pat_q [MAX_PATTERN_LEN];
  logic [LenW-1:0]              len_q;
  logic [MAX_PATTERN_LEN*8-1:0] rev_vec;
  logic [31:0]                  shift_amt;

  always_ff @(posedge clk_i) begin
    if (wr_byte_en_i) begin
      pat_q[wr_pos_i] <= wr_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (wr_len_en_i) begin
      len_q <= wr_len_i;
    end
  end

  // Pattern byte j sits at byte MAX-1-j; shifting down by MAX-len bytes puts
  // pattern byte len-1-d at byte d.
  for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_rev
    assign rev_vec[(MAX_PATTERN_LEN-1-j)*8 +: 8] = pat_q[j];
  end

  assign shift_amt = (32'(MAX_PATTERN_LEN) - 32'(len_q)) << 3;
  assign aligned_o = rev_vec >> shift_amt;

  for (genvar d = 0; d < MAX_PATTERN_LEN; d++) begin : g_care
    assign care_o[d] = 32'(len_q) > 32'(d);
  end

  assign len_o = len_q;

endmodule

`default_nettype wire

@@ design/multi_pattern_scan_with_stats.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_scan_with_stats: streaming multi-pattern scanner with counters
// Top level: request decode, window cell chain, hit flags, file statistics
// and the registered reply path.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid_i/in_ready_o channel: pattern byte loads,
//   pattern lengths, content bytes, end of file and count reads. Content
//   bytes shift through a chain of window cells; every slot is compared
//   against the whole window in the cycle its byte is accepted, and hits
//   stick until end of file.
//   End of file and count reads each give one reply transaction on the
//   out_valid_o/out_ready_i channel through the output register. Other
//   requests give no reply.
//   Throughput is one request per cycle while in_ready_o is high, set by the
//   combinational compare over the cell chain and the parallel counter update.
//   Replies pass through an output register and a skid register; when the
//   receiver stalls, the input keeps accepting until the skid register holds
//   a reply, then in_ready_o drops until the receiver takes one.
//   Reset clears lengths, the window, hit flags and all counters; pattern
//   bytes are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_scan_with_stats #(
  parameter int unsigned NUM_PATTERNS    = mps_pkg::DEF_NUM_PATTERNS,
  parameter int unsigned MAX_PATTERN_LEN = mps_pkg::DEF_MAX_PATTERN_LEN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mps_pkg::REQ_W-1:0]     req_type_i,
  input  logic [mps_pkg::SLOT_FW-1:0]   pattern_slot_i,
  input  logic [mps_pkg::POS_FW-1:0]    byte_position_i,
  input  logic [7:0]                    byte_value_i,
  input  logic [mps_pkg::LEN_FW-1:0]    pattern_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          reply_kind_o,
  output logic                          infected_o,
  output logic [mps_pkg::MASK_W-1:0]    match_mask_o,
  output logic [mps_pkg::CNT_W-1:0]     file_total_o,
  output logic [mps_pkg::CNT_W-1:0]     infected_total_o,
  output logic [mps_pkg::CNT_W-1:0]     slot_hits_o
);
  import mps_pkg::*;

  localparam int unsigned SlotW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int unsigned PosW  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned LenW  = $clog2(MAX_PATTERN_LEN + 1);

  typedef struct packed {
    logic              reply_kind;
    logic              infected;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  inf_total;
    logic [CNT_W-1:0]  hits;
  } reply_t;

  // Request decode.
  logic        acc;
  req_type_e   req;
  logic [31:0] slot_ext, pos_ext, len_ext;
  logic        slot_ok, pos_ok;
  logic [SlotW-1:0] slot_idx;
  logic [PosW-1:0]  pos_idx;
  logic [LenW-1:0]  len_sat;
  logic        is_load, is_length, is_content, is_eof, is_read;
  scan_ctl_t   ctl;

  assign acc      = in_valid_i && in_ready_o;
  assign req      = req_type_e'(req_type_i);
  assign slot_ext = 32'(pattern_slot_i);
  assign pos_ext  = 32'(byte_position_i);
  assign len_ext  = 32'(pattern_length_i);
  assign slot_ok  = slot_ext < 32'(NUM_PATTERNS);
  assign pos_ok   = pos_ext < 32'(MAX_PATTERN_LEN);
  assign slot_idx = slot_ext[SlotW-1:0];
  assign pos_idx  = pos_ext[PosW-1:0];
  assign len_sat  = (len_ext > 32'(MAX_PATTERN_LEN)) ? LenW'(MAX_PATTERN_LEN)
                                                     : len_ext[LenW-1:0];

  always_comb begin
    is_load    = 1'b0;
    is_length  = 1'b0;
    is_content = 1'b0;
    is_eof     = 1'b0;
    is_read    = 1'b0;
    case (req)
      REQ_LOAD:    is_load    = 1'b1;
      REQ_LENGTH:  is_length  = 1'b1;
      REQ_CONTENT: is_content = 1'b1;
      REQ_EOF:     is_eof     = 1'b1;
      REQ_READ:    is_read    = 1'b1;
      default:     ;
    endcase
  end

  assign ctl.shift = acc && is_content;
  assign ctl.clear = acc && is_eof;

  // Pattern slots.
  logic [NUM_PATTERNS-1:0][LenW-1:0]                  slot_len;
  logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0][7:0]  slot_aligned;
  logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0]       slot_care;

  for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_slot
    logic wr_byte_en, wr_len_en;
    assign wr_byte_en = acc && is_load && slot_ok && pos_ok && (slot_idx == SlotW'(s));
    assign wr_len_en  = acc && is_length && slot_ok && (slot_idx == SlotW'(s));

    mps_slot #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_slot (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_byte_en_i (wr_byte_en),
      .wr_pos_i     (pos_idx),
      .wr_byte_i    (byte_value_i),
      .wr_len_en_i  (wr_len_en),
      .wr_len_i     (len_sat),
      .len_o        (slot_len[s]),
      .aligned_o    (slot_aligned[s]),
      .care_o       (slot_care[s])
    );
  end

  // Window cell chain.
  logic [MAX_PATTERN_LEN-1:0][7:0]                    win;
  logic [MAX_PATTERN_LEN-1:0][NUM_PATTERNS-1:0][7:0]  cell_aligned;
  logic [MAX_PATTERN_LEN-1:0][NUM_PATTERNS-1:0]       cell_care;
  logic [MAX_PATTERN_LEN-1:0][NUM_PATTERNS-1:0]       cell_hit;
  logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0]       hit_tr;

  for (genvar d = 0; d < MAX_PATTERN_LEN; d++) begin : g_cell
    logic [7:0] cell_in;
    if (d == 0) begin : g_head
      assign cell_in = byte_value_i;
    end else begin : g_link
      assign cell_in = win[d-1];
    end

    for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_route
      assign cell_aligned[d][s] = slot_aligned[s][d];
      assign cell_care[d][s]    = slot_care[s][d];
      assign hit_tr[s][d]       = cell_hit[d][s];
    end

    mps_cell #(
      .NUM_PATTERNS (NUM_PATTERNS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .byte_i    (cell_in),
      .byte_o    (win[d]),
      .aligned_i (cell_aligned[d]),
      .care_i    (cell_care[d]),
      .hit_o     (cell_hit[d])
    );
  end

  // Hit tracking.
  logic [LenW-1:0]         seen_q, seen_d, seen_inc;
  logic [NUM_PATTERNS-1:0] found_q, found_d;
  logic [NUM_PATTERNS-1:0] match_now, zero_len, eof_flags;
  logic                    eof_inf;

  assign seen_inc = (seen_q == LenW'(MAX_PATTERN_LEN)) ? seen_q : seen_q + LenW'(1);

  for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_match
    assign zero_len[s]  = slot_len[s] == '0;
    assign match_now[s] = (&hit_tr[s]) && !zero_len[s] && (slot_len[s] <= seen_inc);
  end

  assign eof_flags = found_q | zero_len;
  assign eof_inf   = |eof_flags;

  always_comb begin
    seen_d  = seen_q;
    found_d = found_q;
    if (ctl.shift) begin
      seen_d  = seen_inc;
      found_d = found_q | match_now;
    end else if (ctl.clear) begin
      seen_d  = '0;
      found_d = '0;
    end
  end

  // File statistics.
  logic [CNT_W-1:0] files_q, files_d, inf_files_q, inf_files_d;
  logic [CNT_W-1:0] hits_q [NUM_PATTERNS];

  assign files_d     = files_q + CNT_W'(1);
  assign inf_files_d = inf_files_q + CNT_W'(eof_inf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      found_q     <= '0;
      files_q     <= '0;
      inf_files_q <= '0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        hits_q[i] <= '0;
      end
    end else begin
      seen_q  <= seen_d;
      found_q <= found_d;
      if (ctl.clear) begin
        files_q     <= files_d;
        inf_files_q <= inf_files_d;
        for (int i = 0; i < NUM_PATTERNS; i++) begin
          hits_q[i] <= hits_q[i] + CNT_W'(eof_flags[i]);
        end
      end
    end
  end

  // Reply assembly.
  logic [MASK_W-1:0] mask_w;
  reply_t            reply;
  logic              has_reply;

  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NUM_PATTERNS) begin : g_used
      assign mask_w[i] = eof_flags[i];
    end else begin : g_unused
      assign mask_w[i] = 1'b0;
    end
  end

  assign has_reply = acc && (is_eof || is_read);

  always_comb begin
    if (is_eof) begin
      reply.reply_kind = REPLY_VERDICT;
      reply.infected   = eof_inf;
      reply.mask       = mask_w;
      reply.total      = files_d;
      reply.inf_total  = inf_files_d;
      reply.hits       = '0;
    end else begin
      reply.reply_kind = REPLY_COUNT;
      reply.infected   = 1'b0;
      reply.mask       = '0;
      reply.total      = files_q;
      reply.inf_total  = inf_files_q;
      reply.hits       = slot_ok ? hits_q[slot_idx] : '0;
    end
  end

  // Output register with a skid register behind it.
  logic   out_vld_q, skid_vld_q, pop;
  reply_t out_q, skid_q;

  assign pop        = out_vld_q && out_ready_i;
  assign in_ready_o = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (has_reply) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q  <= skid_vld_q;
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_reply) begin
      if (!out_vld_q || pop) begin
        out_q <= reply;
      end else begin
        skid_q <= reply;
      end
    end else if (pop && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign reply_kind_o     = out_q.reply_kind;
  assign infected_o       = out_q.infected;
  assign match_mask_o     = out_q.mask;
  assign file_total_o     = out_q.total;
  assign infected_total_o = out_q.inf_total;
  assign slot_hits_o      = out_q.hits;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a reply while the output register is empty");

  a_reply_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_reply |=> out_vld_q)
    else $error("accepted reply request did not reach the output");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> (found_q == '0) && (seen_q == '0))
    else $error("hit flags or byte count not cleared at end of file");

  a_file_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> files_q == $past(files_q) + CNT_W'(1))
    else $error("file counter did not advance at end of file");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= LenW'(MAX_PATTERN_LEN))
    else $error("byte count ran past the window length");
`endif

endmodule

`default_nettype wire
